// File: rtl/mtem_pkg.sv
// ----------------------------------------------------------------------------
// mtem_pkg
// Shared types and constants for the markup text extent measure unit.
// ----------------------------------------------------------------------------
package mtem_pkg;

    // field widths
    localparam int ADV_W     = 16;  // glyph advance, Q4.12 em
    localparam int CODE_W    = 8;   // character code
    localparam int ACC_W     = 32;  // line advance accumulator, Q20.12 em
    localparam int LINES_W   = 16;  // line counter
    localparam int CFG_W     = 16;  // configuration data
    localparam int CFG_IDX_W = 1;   // configuration register index
    localparam int ACT_W     = 2;   // action code
    localparam int RES_W     = 32;  // width / height result, Q16.16 px

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FONT_SIZE_RST   = 16'd256;
    localparam logic [CFG_W-1:0] LINE_HEIGHT_RST = 16'd4096;

    // action codes carried on tuser
    localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MEASURE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FINISH  = 2'd2;

    // character codes
    localparam logic [CODE_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CODE_W-1:0] CH_C       = 8'h63;
    localparam logic [CODE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CODE_W-1:0] CH_SEVEN   = 8'h37;
    localparam logic [CODE_W-1:0] CH_NEWLINE = 8'h0A;

    localparam logic [LINES_W-1:0] LINES_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAS,
        S_PLAIN,
        S_MUL1,
        S_MUL2,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,    // write table entry from the input transfer
        OP_LOAD,     // capture code, start table read
        OP_MEASURE,  // escape-aware step on the captured code
        OP_PLAIN,    // replay of the captured code with no escape pending
        OP_MUL1,     // widest * font_size, line_height * font_size
        OP_MUL2,     // lines * (line_height * font_size)
        OP_OUT       // load result register, clear string state
    } t_op;

    typedef struct packed {
        logic take;  // input transfer this cycle
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic replay;    // pending '$' resolved, same code must be replayed
        logic out_free;  // result register can take a new result
    } t_dp_stat;

endpackage

// File: rtl/markup_text_extent_measure_unit.sv
// ----------------------------------------------------------------------------
// markup_text_extent_measure_unit
// Measures width and height of a text string carrying inline color markup.
// ----------------------------------------------------------------------------
// Items come in on the slave stream, one transfer each: tuser selects write
// (load a Q4.12 advance into the glyph table at the character code), measure
// (one character) or finish (emit the extent). "$c" followed by a digit 0-7
// is a color code and is skipped; a lone '$' is measured with the '$' advance.
// Each finish gives one master transfer with width and height in Q16.16
// pixels, saturating; an empty string gives zeros. Per item: a write or an
// unused action is taken in the idle state; a measure goes through the
// registered table read, then the accumulate step, plus a replay step when
// it resolves a pending '$'; a finish goes through two multiplier stages plus
// any wait for the result register to drain. The table is cleared by reset
// through per-entry valid bits, so no clearing pass is needed. Configuration
// writes (font size Q12.4, line height Q4.12) must be made while idle.
// ----------------------------------------------------------------------------
module markup_text_extent_measure_unit #(
    parameter int GLYPHS = 256  // advance table entries, 128..4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] character, [23:8] advance_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] action

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] width, [63:32] height

    input  logic                            i_cfg_wr_en,
    input  logic [mtem_pkg::CFG_IDX_W-1:0]  i_cfg_index,  // 0 font_size, 1 line_height
    input  logic [mtem_pkg::CFG_W-1:0]      i_cfg_wdata
);

    mtem_pkg::t_dp_cmd  cmd;
    mtem_pkg::t_dp_stat stat;

    logic [mtem_pkg::RES_W-1:0] res_width;
    logic [mtem_pkg::RES_W-1:0] res_height;

    // sequencer: accepts only in its idle state, then walks the datapath
    mtem_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_action (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    // datapath holds the table, string state and the result register,
    // so a finished result can wait while the next string streams in
    mtem_dp #(
        .GLYPHS (GLYPHS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_code      (s_axis_tdata[7:0]),
        .i_value     (s_axis_tdata[23:8]),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_width     (res_width),
        .o_height    (res_height)
    );

    assign m_axis_tdata = {res_height, res_width};

endmodule

// File: rtl/mtem_ram.sv
// ----------------------------------------------------------------------------
// mtem_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mtem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/mtem_ctrl.sv
// ----------------------------------------------------------------------------
// mtem_ctrl
// Sequencer: takes input transfers, steps the datapath through measure and
// finish operations.
// ----------------------------------------------------------------------------
module mtem_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [mtem_pkg::ACT_W-1:0]  i_action,
    output logic                        o_ready,
    input  mtem_pkg::t_dp_stat          i_stat,
    output mtem_pkg::t_dp_cmd           o_cmd
);

    mtem_pkg::t_state r_state;
    mtem_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtem_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtem_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_action == mtem_pkg::ACT_MEASURE) begin
                        n_state = mtem_pkg::S_MEAS;
                    end else if (i_action == mtem_pkg::ACT_FINISH) begin
                        n_state = mtem_pkg::S_MUL1;
                    end
                end
            end
            mtem_pkg::S_MEAS: begin
                n_state = i_stat.replay ? mtem_pkg::S_PLAIN : mtem_pkg::S_IDLE;
            end
            mtem_pkg::S_PLAIN: n_state = mtem_pkg::S_IDLE;
            mtem_pkg::S_MUL1:  n_state = mtem_pkg::S_MUL2;
            mtem_pkg::S_MUL2:  n_state = mtem_pkg::S_OUT;
            mtem_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = mtem_pkg::S_IDLE;
                end
            end
            default: n_state = mtem_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready    = 1'b0;
        o_cmd.take = 1'b0;
        o_cmd.op   = mtem_pkg::OP_NONE;
        unique case (r_state)
            mtem_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
                if (i_valid) begin
                    unique case (i_action)
                        mtem_pkg::ACT_WRITE:   o_cmd.op = mtem_pkg::OP_WRITE;
                        mtem_pkg::ACT_MEASURE: o_cmd.op = mtem_pkg::OP_LOAD;
                        default:               o_cmd.op = mtem_pkg::OP_NONE;
                    endcase
                end
            end
            mtem_pkg::S_MEAS:  o_cmd.op = mtem_pkg::OP_MEASURE;
            mtem_pkg::S_PLAIN: o_cmd.op = mtem_pkg::OP_PLAIN;
            mtem_pkg::S_MUL1:  o_cmd.op = mtem_pkg::OP_MUL1;
            mtem_pkg::S_MUL2:  o_cmd.op = mtem_pkg::OP_MUL2;
            mtem_pkg::S_OUT: begin
                o_cmd.op = i_stat.out_free ? mtem_pkg::OP_OUT : mtem_pkg::OP_NONE;
            end
            default: o_cmd.op = mtem_pkg::OP_NONE;
        endcase
    end

endmodule

// File: rtl/mtem_dp.sv
// ----------------------------------------------------------------------------
// mtem_dp
// Datapath: advance table, escape flags, line accumulators, finish
// multipliers and result register.
// ----------------------------------------------------------------------------
module mtem_dp #(
    parameter int GLYPHS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mtem_pkg::t_dp_cmd               i_cmd,
    output mtem_pkg::t_dp_stat              o_stat,
    input  logic [mtem_pkg::CODE_W-1:0]     i_code,
    input  logic [mtem_pkg::ADV_W-1:0]      i_value,
    input  logic                            i_cfg_wr_en,
    input  logic [mtem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtem_pkg::CFG_W-1:0]      i_cfg_wdata,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mtem_pkg::RES_W-1:0]      o_width,
    output logic [mtem_pkg::RES_W-1:0]      o_height
);

    // only codes an 8-bit character can reach need storage
    localparam int CODES = 1 << mtem_pkg::CODE_W;
    localparam int DEPTH = (GLYPHS < CODES) ? GLYPHS : CODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW_W  = mtem_pkg::ACC_W + mtem_pkg::CFG_W;
    localparam int LF_W  = 2 * mtem_pkg::CFG_W;
    localparam int MH_W  = mtem_pkg::LINES_W + LF_W;

    // config
    logic [mtem_pkg::CFG_W-1:0] r_font;
    logic [mtem_pkg::CFG_W-1:0] r_lh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font <= mtem_pkg::FONT_SIZE_RST;
            r_lh   <= mtem_pkg::LINE_HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == mtem_pkg::REG_FONT_SIZE) begin
                r_font <= i_cfg_wdata;
            end
            if (i_cfg_index == mtem_pkg::REG_LINE_HEIGHT) begin
                r_lh <= i_cfg_wdata;
            end
        end
    end

    // advance table, valid bits stand in for the cleared reset contents
    logic                         in_range;
    logic                         tbl_we;
    logic                         tbl_re;
    logic [AW-1:0]                tbl_addr;
    logic [mtem_pkg::ADV_W-1:0]   tbl_rdata;
    logic                         r_valid [DEPTH];
    logic                         r_rd_ok;
    logic [mtem_pkg::ADV_W-1:0]   r_dollar_adv;
    logic [mtem_pkg::CODE_W-1:0]  r_code;

    assign in_range = ({1'b0, i_code} < (mtem_pkg::CODE_W + 1)'(DEPTH));
    assign tbl_addr = i_code[AW-1:0];
    assign tbl_we   = (i_cmd.op == mtem_pkg::OP_WRITE) && in_range;
    assign tbl_re   = (i_cmd.op == mtem_pkg::OP_LOAD);

    mtem_ram #(
        .WIDTH (mtem_pkg::ADV_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (tbl_addr),
        .i_wr_data (i_value),
        .i_rd_en   (tbl_re),
        .i_rd_addr (tbl_addr),
        .o_rd_data (tbl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_dollar_adv <= '0;
            r_rd_ok      <= 1'b0;
        end else begin
            if (tbl_we) begin
                r_valid[tbl_addr] <= 1'b1;
                if (i_code == mtem_pkg::CH_DOLLAR) begin
                    r_dollar_adv <= i_value;
                end
            end
            if (tbl_re) begin
                r_rd_ok <= in_range && r_valid[tbl_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_code <= i_code;
        end
    end

    // string state
    logic                          r_esc, n_esc;
    logic                          r_dig, n_dig;
    logic                          r_any, n_any;
    logic [mtem_pkg::ACC_W-1:0]    r_line, n_line;
    logic [mtem_pkg::ACC_W-1:0]    r_wide, n_wide;
    logic [mtem_pkg::LINES_W-1:0]  r_lines, n_lines;

    logic                          is_dollar, is_c, is_nl, is_digit;
    logic                          do_add, do_nl, add_dollar;
    logic [mtem_pkg::ADV_W-1:0]    adv;
    logic [mtem_pkg::ADV_W-1:0]    add_opnd;
    logic [mtem_pkg::ACC_W:0]      sum;
    logic [mtem_pkg::ACC_W-1:0]    sum_sat;

    assign is_dollar = (r_code == mtem_pkg::CH_DOLLAR);
    assign is_c      = (r_code == mtem_pkg::CH_C);
    assign is_nl     = (r_code == mtem_pkg::CH_NEWLINE);
    assign is_digit  = (r_code >= mtem_pkg::CH_ZERO) && (r_code <= mtem_pkg::CH_SEVEN);
    assign adv       = r_rd_ok ? tbl_rdata : '0;
    assign add_opnd  = add_dollar ? r_dollar_adv : adv;
    assign sum       = {1'b0, r_line} + {{(mtem_pkg::ACC_W + 1 - mtem_pkg::ADV_W){1'b0}}, add_opnd};
    assign sum_sat   = sum[mtem_pkg::ACC_W] ? '1 : sum[mtem_pkg::ACC_W-1:0];

    always_comb begin
        n_esc      = r_esc;
        n_dig      = r_dig;
        n_any      = r_any;
        n_line     = r_line;
        n_wide     = r_wide;
        n_lines    = r_lines;
        do_add     = 1'b0;
        do_nl      = 1'b0;
        add_dollar = 1'b0;
        unique case (i_cmd.op)
            mtem_pkg::OP_MEASURE: begin
                n_any = 1'b1;
                if (r_esc && r_dig) begin
                    // end of a color code, or a plain glyph after "$c"
                    n_esc = 1'b0;
                    n_dig = 1'b0;
                    if (!is_digit) begin
                        do_nl  = is_nl;
                        do_add = !is_nl;
                    end
                end else if (r_esc) begin
                    if (is_c) begin
                        n_dig = 1'b1;
                    end else begin
                        // lone '$': measure it, replay the code next cycle
                        n_esc      = 1'b0;
                        do_add     = 1'b1;
                        add_dollar = 1'b1;
                    end
                end else if (is_dollar) begin
                    n_esc = 1'b1;
                end else begin
                    do_nl  = is_nl;
                    do_add = !is_nl;
                end
            end
            mtem_pkg::OP_PLAIN: begin
                if (is_dollar) begin
                    n_esc = 1'b1;
                end else begin
                    do_nl  = is_nl;
                    do_add = !is_nl;
                end
            end
            mtem_pkg::OP_OUT: begin
                n_esc   = 1'b0;
                n_dig   = 1'b0;
                n_any   = 1'b0;
                n_line  = '0;
                n_wide  = '0;
                n_lines = mtem_pkg::LINES_W'(1);
            end
            default: begin
            end
        endcase
        if (do_nl) begin
            n_line = '0;
            if (r_lines != mtem_pkg::LINES_MAX) begin
                n_lines = r_lines + mtem_pkg::LINES_W'(1);
            end
        end
        if (do_add) begin
            n_line = sum_sat;
            if (sum_sat > r_wide) begin
                n_wide = sum_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= 1'b0;
            r_dig   <= 1'b0;
            r_any   <= 1'b0;
            r_line  <= '0;
            r_wide  <= '0;
            r_lines <= mtem_pkg::LINES_W'(1);
        end else begin
            r_esc   <= n_esc;
            r_dig   <= n_dig;
            r_any   <= n_any;
            r_line  <= n_line;
            r_wide  <= n_wide;
            r_lines <= n_lines;
        end
    end

    // finish: two multiplier stages
    logic [MW_W-1:0] r_wprod;
    logic [LF_W-1:0] r_lhfs;
    logic [MH_W-1:0] r_hprod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mtem_pkg::OP_MUL1) begin
            r_wprod <= MW_W'(r_wide) * MW_W'(r_font);
            r_lhfs  <= LF_W'(r_lh) * LF_W'(r_font);
        end
        if (i_cmd.op == mtem_pkg::OP_MUL2) begin
            r_hprod <= MH_W'(r_lines) * MH_W'(r_lhfs);
        end
    end

    // result register
    logic                        r_out_valid;
    logic [mtem_pkg::RES_W-1:0]  r_width;
    logic [mtem_pkg::RES_W-1:0]  r_height;
    logic [mtem_pkg::RES_W-1:0]  w_sat;
    logic [mtem_pkg::RES_W-1:0]  h_sat;

    assign w_sat = (|r_wprod[MW_W-1:mtem_pkg::RES_W]) ? '1 : r_wprod[mtem_pkg::RES_W-1:0];
    assign h_sat = (|r_hprod[MH_W-1:mtem_pkg::RES_W]) ? '1 : r_hprod[mtem_pkg::RES_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == mtem_pkg::OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mtem_pkg::OP_OUT) begin
            r_width  <= r_any ? w_sat : '0;
            r_height <= r_any ? h_sat : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_width         = r_width;
    assign o_height        = r_height;
    assign o_stat.replay   = add_dollar;
    assign o_stat.out_free = !r_out_valid || i_ready;

endmodule

// File: rtl/mtem_checker.sv
// ----------------------------------------------------------------------------
// mtem_checker
// Port-level checks on the markup text extent measure unit, bound to the top.
// ----------------------------------------------------------------------------
module mtem_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata
);

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // finish goes through the multiplier stages before the next transfer
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tuser == mtem_pkg::ACT_FINISH) |=> !s_axis_tready)
        else $error("input taken right after a finish");

    // measure waits on the table read
    a_measure_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tuser == mtem_pkg::ACT_MEASURE) |=> !s_axis_tready)
        else $error("input taken right after a measure");

    // table writes complete in the accept cycle
    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tuser == mtem_pkg::ACT_WRITE) |=> s_axis_tready)
        else $error("not ready after a table write");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind markup_text_extent_measure_unit mtem_checker u_mtem_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for markup_text_extent_measure_unit: streams write,
// measure and finish transfers with random gaps and output stalls, predicts
// each extent from its own model of the string state and checks every field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          GLYPH_CNT  = 256;
    localparam logic [1:0]  ACT_UNUSED = 2'd3;     // ignored by the block
    localparam int unsigned CYCLE_CAP  = 2_500_000;

    // one slave-side transfer
    typedef struct packed {
        logic [mtem_pkg::ACT_W-1:0]  action;
        logic [mtem_pkg::CODE_W-1:0] code;
        logic [mtem_pkg::ADV_W-1:0]  adv;
    } t_text_op;

    // one master-side transfer
    typedef struct packed {
        logic [mtem_pkg::RES_W-1:0] width;
        logic [mtem_pkg::RES_W-1:0] height;
    } t_extent;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;      // [7:0] character, [23:8] advance_value
    logic [1:0]  s_axis_tuser = '0;      // [1:0] action

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // [31:0] width, [63:32] height

    logic                           i_cfg_wr_en = 1'b0;
    logic [mtem_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [mtem_pkg::CFG_W-1:0]     i_cfg_wdata = '0;

    markup_text_extent_measure_unit #(
        .GLYPHS (GLYPH_CNT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Extent predictor state: glyph table, escape tracking, line metrics and
    // its own copy of the two config registers.
    // ------------------------------------------------------------------------
    logic [mtem_pkg::ADV_W-1:0]   adv_tab [GLYPH_CNT];
    logic                         esc_open;     // '$' seen, waiting for 'c'
    logic                         digit_open;   // "$c" seen, waiting for the digit
    logic [mtem_pkg::ACC_W-1:0]   run_len;      // advance of the current line
    logic [mtem_pkg::ACC_W-1:0]   peak_len;     // widest line so far
    logic [mtem_pkg::LINES_W-1:0] line_cnt;
    logic                         seen_any;     // any measure since the last finish
    logic [mtem_pkg::CFG_W-1:0]   font_cfg = mtem_pkg::FONT_SIZE_RST;
    logic [mtem_pkg::CFG_W-1:0]   lh_cfg   = mtem_pkg::LINE_HEIGHT_RST;

    t_extent  extent_q[$];   // extents still owed by the block
    t_text_op op_q[$];       // transfers waiting for the driver

    t_text_op    drv_op;
    t_extent     want_ext;
    logic        in_taken = 1'b0;
    logic        calm = 1'b0;        // no gaps, no stalls
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned sent_cnt = 0;
    int unsigned queued_cnt = 0;
    int unsigned live_cnt = 0;       // pushed transfers that do something
    int unsigned errors = 0;
    int unsigned cycles = 0;

    initial begin
        for (int i = 0; i < GLYPH_CNT; i++) adv_tab[i] = '0;
        esc_open   = 1'b0;
        digit_open = 1'b0;
        run_len    = '0;
        peak_len   = '0;
        line_cnt   = mtem_pkg::LINES_W'(1);
        seen_any   = 1'b0;
    end

    task automatic note_error(string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic void add_adv(logic [mtem_pkg::CODE_W-1:0] ch);
        logic [mtem_pkg::ACC_W:0] sum;
        sum = {1'b0, run_len}
            + {{(mtem_pkg::ACC_W + 1 - mtem_pkg::ADV_W){1'b0}}, adv_tab[ch]};
        run_len = sum[mtem_pkg::ACC_W] ? '1 : sum[mtem_pkg::ACC_W-1:0];
        if (run_len > peak_len) peak_len = run_len;
    endfunction

    // character with no escape in force
    function automatic void plain_char(logic [mtem_pkg::CODE_W-1:0] ch);
        if (ch == mtem_pkg::CH_NEWLINE) begin
            if (line_cnt != mtem_pkg::LINES_MAX) line_cnt = line_cnt + mtem_pkg::LINES_W'(1);
            run_len = '0;
        end else begin
            add_adv(ch);
        end
    endfunction

    function automatic void measure_char(logic [mtem_pkg::CODE_W-1:0] ch);
        seen_any = 1'b1;
        if (esc_open) begin
            if (digit_open) begin
                esc_open   = 1'b0;
                digit_open = 1'b0;
                // color code
                if (ch >= mtem_pkg::CH_ZERO && ch <= mtem_pkg::CH_SEVEN) return;
                plain_char(ch);                               // no new escape
                return;
            end
            if (ch == mtem_pkg::CH_C) begin
                digit_open = 1'b1;
                return;
            end
            // lone '$': charge its advance, then redo this character
            esc_open = 1'b0;
            add_adv(mtem_pkg::CH_DOLLAR);
        end
        if (ch == mtem_pkg::CH_DOLLAR) begin
            esc_open = 1'b1;
            return;
        end
        plain_char(ch);
    endfunction

    function automatic void finish_string();
        logic [47:0] w;
        logic [31:0] lh_px;
        logic [63:0] h;
        t_extent     ext;
        ext = '0;
        if (seen_any) begin
            w     = 48'(peak_len) * 48'(font_cfg);
            lh_px = 32'(lh_cfg) * 32'(font_cfg);
            h     = 64'(line_cnt) * 64'(lh_px);
            ext.width  = (w > 48'hFFFF_FFFF) ? '1 : w[31:0];
            ext.height = (h > 64'hFFFF_FFFF) ? '1 : h[31:0];
        end
        extent_q.push_back(ext);
        // pending escapes are dropped along with the line state
        esc_open   = 1'b0;
        digit_open = 1'b0;
        run_len    = '0;
        peak_len   = '0;
        line_cnt   = mtem_pkg::LINES_W'(1);
        seen_any   = 1'b0;
    endfunction

    function automatic void track_item(logic [mtem_pkg::ACT_W-1:0] act,
                                       logic [mtem_pkg::CODE_W-1:0] ch,
                                       logic [mtem_pkg::ADV_W-1:0] adv);
        case (act)
            mtem_pkg::ACT_WRITE:   adv_tab[ch] = adv;
            mtem_pkg::ACT_MEASURE: measure_char(ch);
            mtem_pkg::ACT_FINISH:  finish_string();
            default: ;
        endcase
    endfunction

    // mostly back-to-back, a fair share of short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: slave-side stream, changes on the falling edge. A transfer is
    // held until the rising edge that takes it, then an optional gap follows.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && !(s_axis_tvalid && !in_taken)) begin
            if (gap_left != 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left      <= gap_left - 1;
            end else if (op_q.size() != 0) begin
                drv_op         = op_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= drv_op.action;
                s_axis_tdata  <= {drv_op.adv, drv_op.code};
                gap_left      <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // master-side back-pressure
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: on the rising edge, check finished extents against the oldest
    // prediction, then feed each accepted input transfer to the predictor.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (extent_q.size() == 0) begin
                    note_error($sformatf("unexpected extent transfer %h", m_axis_tdata));
                end else begin
                    want_ext = extent_q.pop_front();
                    if (m_axis_tdata[31:0] !== want_ext.width)
                        note_error($sformatf("width got %h want %h",
                                             m_axis_tdata[31:0], want_ext.width));
                    if (m_axis_tdata[63:32] !== want_ext.height)
                        note_error($sformatf("height got %h want %h",
                                             m_axis_tdata[63:32], want_ext.height));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sent_cnt++;
                track_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8]);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [mtem_pkg::CODE_W-1:0] rnd_code();
        return mtem_pkg::CODE_W'($urandom);
    endfunction

    function automatic logic [mtem_pkg::ADV_W-1:0] rnd_adv();
        return mtem_pkg::ADV_W'($urandom);
    endfunction

    task automatic push_op(logic [mtem_pkg::ACT_W-1:0] act,
                           logic [mtem_pkg::CODE_W-1:0] ch,
                           logic [mtem_pkg::ADV_W-1:0] adv);
        t_text_op op;
        op.action = act;
        op.code   = ch;
        op.adv    = adv;
        op_q.push_back(op);
        queued_cnt++;
        if (act != ACT_UNUSED) live_cnt++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_op(mtem_pkg::ACT_MEASURE, s[i], rnd_adv());
    endtask

    // advance values: full range, with the ends hit often
    function automatic logic [mtem_pkg::ADV_W-1:0] pick_adv();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return '1;
        if (r < 25) return '0;
        if (r < 60) return mtem_pkg::ADV_W'($urandom_range(0, 16'h3000));
        return rnd_adv();
    endfunction

    // characters biased toward markup and the digit boundaries
    function automatic logic [mtem_pkg::CODE_W-1:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return mtem_pkg::CODE_W'($urandom_range(8'h61, 8'h68));  // 'a'..'h'
        if (r < 45) return mtem_pkg::CH_DOLLAR;
        if (r < 55) return mtem_pkg::CH_C;
        if (r < 70) return mtem_pkg::CODE_W'($urandom_range(8'h2F, 8'h38));  // '/'..'8'
        if (r < 78) return mtem_pkg::CH_NEWLINE;
        return rnd_code();
    endfunction

    // one string built mostly from well-formed markup, ended by a finish
    task automatic push_random_string();
        int unsigned n;
        int unsigned r;
        n = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 16);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                push_op(mtem_pkg::ACT_MEASURE, pick_char(), rnd_adv());
            end else if (r < 55) begin                    // color code
                push_op(mtem_pkg::ACT_MEASURE, mtem_pkg::CH_DOLLAR, rnd_adv());
                push_op(mtem_pkg::ACT_MEASURE, mtem_pkg::CH_C, rnd_adv());
                push_op(mtem_pkg::ACT_MEASURE,
                        mtem_pkg::CODE_W'($urandom_range(mtem_pkg::CH_ZERO,
                                                         mtem_pkg::CH_SEVEN)),
                        rnd_adv());
            end else if (r < 62) begin                    // "$c" then a random character
                push_op(mtem_pkg::ACT_MEASURE, mtem_pkg::CH_DOLLAR, rnd_adv());
                push_op(mtem_pkg::ACT_MEASURE, mtem_pkg::CH_C, rnd_adv());
                push_op(mtem_pkg::ACT_MEASURE, pick_char(), rnd_adv());
            end else if (r < 70) begin                    // '$' then a random character
                push_op(mtem_pkg::ACT_MEASURE, mtem_pkg::CH_DOLLAR, rnd_adv());
                push_op(mtem_pkg::ACT_MEASURE, pick_char(), rnd_adv());
            end else if (r < 78) begin
                push_op(mtem_pkg::ACT_MEASURE, mtem_pkg::CH_NEWLINE, rnd_adv());
            end else if (r < 83) begin                    // table update mid-string
                push_op(mtem_pkg::ACT_WRITE, pick_char(), pick_adv());
            end else if (r < 85) begin
                push_op(ACT_UNUSED, rnd_code(), rnd_adv());
            end else begin
                push_op(mtem_pkg::ACT_MEASURE, rnd_code(), rnd_adv());
            end
        end
        // now and then leave an escape open at the end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            push_op(mtem_pkg::ACT_MEASURE, mtem_pkg::CH_DOLLAR, rnd_adv());
        end else if (r < 9) begin
            push_op(mtem_pkg::ACT_MEASURE, mtem_pkg::CH_DOLLAR, rnd_adv());
            push_op(mtem_pkg::ACT_MEASURE, mtem_pkg::CH_C, rnd_adv());
        end
        push_op(mtem_pkg::ACT_FINISH, rnd_code(), rnd_adv());
    endtask

    // all transfers taken and all extents back, then let the pipeline drain
    task automatic wait_idle();
        do @(negedge i_clk); while (sent_cnt != queued_cnt || extent_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [mtem_pkg::CFG_IDX_W-1:0] idx,
                             logic [mtem_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        if (idx == mtem_pkg::REG_FONT_SIZE) font_cfg = val;
        else lh_cfg = val;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [mtem_pkg::CFG_W-1:0] fsz;
        logic [mtem_pkg::CFG_W-1:0] lht;
        int unsigned                mark;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset config: empty string, table extremes, markup corners
        push_op(mtem_pkg::ACT_FINISH, 8'h00, 16'h0000);
        push_op(mtem_pkg::ACT_WRITE, mtem_pkg::CH_DOLLAR, 16'h1000);
        push_op(mtem_pkg::ACT_WRITE, mtem_pkg::CH_C, 16'h0800);
        push_op(mtem_pkg::ACT_WRITE, 8'h61, 16'h0C00);
        push_op(mtem_pkg::ACT_WRITE, 8'h38, 16'h0400);
        push_op(mtem_pkg::ACT_WRITE, 8'hFF, 16'hFFFF);
        // color, '8' after "$c", '$' after "$c", '$' then other, '$' then newline
        push_text("$c3a$c8$c$$x$\n");
        push_op(mtem_pkg::ACT_MEASURE, 8'hFF, 16'hFFFF);
        push_op(mtem_pkg::ACT_MEASURE, 8'h00, 16'h0000);
        push_op(ACT_UNUSED, 8'hFF, 16'hFFFF);
        push_op(mtem_pkg::ACT_FINISH, 8'hFF, 16'hFFFF);
        push_text("a$");                           // dangling '$' dropped
        push_op(mtem_pkg::ACT_FINISH, 8'h00, 16'h0000);

        // random phases, each under its own register setting
        for (int ph = 0; ph < 7; ph++) begin
            wait_idle();
            case (ph)
                0: begin fsz = 16'h0000; lht = 16'h0000; end
                1: begin fsz = 16'hFFFF; lht = 16'hFFFF; end
                2: begin fsz = 16'h0001; lht = 16'h0001; end
                3: begin fsz = 16'h0010; lht = 16'h1000; end
                default: begin
                    fsz = mtem_pkg::CFG_W'($urandom);
                    lht = mtem_pkg::CFG_W'($urandom);
                end
            endcase
            if (ph[0]) begin
                cfg_write(mtem_pkg::REG_LINE_HEIGHT, lht);
                cfg_write(mtem_pkg::REG_FONT_SIZE, fsz);
            end else begin
                cfg_write(mtem_pkg::REG_FONT_SIZE, fsz);
                cfg_write(mtem_pkg::REG_LINE_HEIGHT, lht);
            end
            calm = (ph == 5);
            mark = live_cnt;
            for (int k = 0; k < 12; k++) push_op(mtem_pkg::ACT_WRITE, pick_char(), pick_adv());
            while (live_cnt - mark < 240) push_random_string();
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
